FILE: hw/rtl/i2ccd_pkg.sv
package i2ccd_pkg;

  // Divisor ranges
  localparam int unsigned SAMPLE_DIV_MAX  = 8;
  localparam int unsigned STEP_DIV_MAX    = 64;
  localparam int unsigned HS_STEP_DIV_MAX = 8;

  // Field widths
  localparam int unsigned CLOCK_W  = 24;
  localparam int unsigned TARGET_W = 16;
  localparam int unsigned SAMPLE_W = 3;
  localparam int unsigned STEP_W   = 6;
  localparam int unsigned RATE_W   = 23;

  // Divider widths: half clock over a divisor product of at most 512
  localparam int unsigned HALF_W = CLOCK_W - 1;
  localparam int unsigned DSR_W  = 10;
  localparam int unsigned CNT_W  = 5;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [SAMPLE_W-1:0] SAMPLE_LAST = SAMPLE_W'(SAMPLE_DIV_MAX - 1);
  localparam logic [STEP_W-1:0]   STEP_LAST   = STEP_W'(STEP_DIV_MAX - 1);
  localparam logic [STEP_W-1:0]   HS_STEP_LAST = STEP_W'(HS_STEP_DIV_MAX - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_WAIT,
    S_EVAL,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/i2ccd_div.sv
module i2ccd_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [i2ccd_pkg::HALF_W-1:0]     dividend,
  input  logic [i2ccd_pkg::DSR_W-1:0]      divisor,
  output logic                             done,
  output logic [i2ccd_pkg::HALF_W-1:0]     quotient
);
  import i2ccd_pkg::*;

  logic [HALF_W-1:0] quo_r, quo_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DSR_W:0]    rem_sh;
  logic [DSR_W:0]    rem_sub;
  logic              ge;

  // One restoring step a cycle, quotient bits shift in at the bottom
  always_comb begin
    rem_sh  = {rem_r, quo_r[HALF_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    ge      = (rem_sh >= {1'b0, dsr_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[HALF_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(HALF_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/i2c_clock_divider_search.sv
// Each request searches 512 divisor pairs, or 64 in high-speed mode; each pair passes
// through load, a run of the shared 23-step restoring divider and evaluation, in turn.
// The next request is taken once the previous result sits in the output register.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_tvalid.
module i2c_clock_divider_search (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [23:0] source_clock, [39:24] target_rate
  input  logic [i2ccd_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] high_speed
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [2:0] sample_field, [8:3] step_field, [9] high_speed_enable,
  // [32:10] achieved_rate, [39:33] zero
  output logic [i2ccd_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] status
  output logic                                 out_tuser
);
  import i2ccd_pkg::*;

  state_t state_r, state_nxt;

  // Request held for the whole search
  logic [HALF_W-1:0]   half_r, half_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;
  logic                hs_r, hs_nxt;

  // Pair counters, held as divisor minus one
  logic [SAMPLE_W-1:0] s_idx_r, s_idx_nxt;
  logic [STEP_W-1:0]   t_idx_r, t_idx_nxt;

  // Best pair so far
  logic [CLOCK_W-1:0]  best_r, best_nxt;
  logic [SAMPLE_W-1:0] best_s_r, best_s_nxt;
  logic [STEP_W-1:0]   best_t_r, best_t_nxt;
  logic [RATE_W-1:0]   best_rate_r, best_rate_nxt;
  logic                kept_r, kept_nxt;
  logic [RATE_W-1:0]   last_rate_r, last_rate_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;

  logic                  div_start;
  logic                  div_done;
  logic [HALF_W-1:0]     div_quo;
  logic [DSR_W-1:0]      div_dsr;
  logic [10:0]           prod;
  logic [STEP_W-1:0]     step_last;
  logic                  last_pair;
  logic                  in_fire;
  logic                  out_free;
  logic [TARGET_W-1:0]   gap;
  logic                  fits;
  logic                  better;
  logic [SAMPLE_W-1:0]   fin_s;
  logic [STEP_W-1:0]     fin_t;
  logic [RATE_W-1:0]     fin_rate;
  logic                  over;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign step_last = hs_r ? HS_STEP_LAST : STEP_LAST;
  assign last_pair = (s_idx_r == SAMPLE_LAST) && (t_idx_r == step_last);

  // Divisor product s*t, at most 512
  assign prod    = ({8'd0, s_idx_r} + 11'd1) * ({5'd0, t_idx_r} + 11'd1);
  assign div_dsr = prod[DSR_W-1:0];

  // Shortfall test on the fresh quotient
  assign fits   = (div_quo <= {7'd0, target_r});
  assign gap    = target_r - div_quo[TARGET_W-1:0];
  assign better = fits && ({8'd0, gap} < best_r);

  // Fall back to the largest divisors when no pair was kept; the last pair
  // tried is exactly that fallback, so its rate is already at hand
  assign fin_s    = kept_r ? best_s_r : SAMPLE_LAST;
  assign fin_t    = kept_r ? best_t_r : step_last;
  assign fin_rate = kept_r ? best_rate_r : last_rate_r;
  assign over     = (fin_rate > {7'd0, target_r});

  i2ccd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (half_r),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_WAIT;
      S_WAIT: if (div_done) state_nxt = S_EVAL;
      S_EVAL: state_nxt = last_pair ? S_DONE : S_LOAD;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_tready     = 1'b0;
    div_start     = 1'b0;
    half_nxt      = half_r;
    target_nxt    = target_r;
    hs_nxt        = hs_r;
    s_idx_nxt     = s_idx_r;
    t_idx_nxt     = t_idx_r;
    best_nxt      = best_r;
    best_s_nxt    = best_s_r;
    best_t_nxt    = best_t_r;
    best_rate_nxt = best_rate_r;
    kept_nxt      = kept_r;
    last_rate_nxt = last_rate_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          // Latch the request and open the search
          half_nxt   = in_tdata[CLOCK_W-1:1];
          target_nxt = in_tdata[CLOCK_W +: TARGET_W];
          hs_nxt     = in_tuser;
          best_nxt   = in_tdata[CLOCK_W-1:0];
          s_idx_nxt  = '0;
          t_idx_nxt  = '0;
          kept_nxt   = 1'b0;
        end
      end
      S_LOAD: div_start = 1'b1;
      S_WAIT: ;
      S_EVAL: begin
        last_rate_nxt = div_quo;
        if (better) begin
          best_nxt      = {8'd0, gap};
          best_s_nxt    = s_idx_r;
          best_t_nxt    = t_idx_r;
          best_rate_nxt = div_quo;
          kept_nxt      = 1'b1;
        end
        // Advance step inner, sample outer
        if (t_idx_r == step_last) begin
          t_idx_nxt = '0;
          s_idx_nxt = s_idx_r + SAMPLE_W'(1);
        end else begin
          t_idx_nxt = t_idx_r + STEP_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = over;
          if (over) begin
            out_data_nxt = '0;
          end else begin
            out_data_nxt = {7'd0, fin_rate, hs_r, fin_t, fin_s};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    half_r      <= half_nxt;
    target_r    <= target_nxt;
    hs_r        <= hs_nxt;
    s_idx_r     <= s_idx_nxt;
    t_idx_r     <= t_idx_nxt;
    best_r      <= best_nxt;
    best_s_r    <= best_s_nxt;
    best_t_r    <= best_t_nxt;
    best_rate_r <= best_rate_nxt;
    kept_r      <= kept_nxt;
    last_rate_r <= last_rate_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: tb/sv/i2c_clock_divider_search_tb.sv
module i2c_clock_divider_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2ccd_pkg::*;

  // The drain outlasts the longest search (512 pairs), so that a stray result
  // would still show at the end.
  localparam int unsigned DRAIN_CYCLES = 13400;
  localparam int unsigned CYCLE_LIMIT  = 6000000;
  localparam int unsigned HOLD_CYCLES  = 30000;
  localparam int unsigned RANDOM_REQS  = 100;

  typedef struct {
    logic [CLOCK_W-1:0]  clock;
    logic [TARGET_W-1:0] target;
    logic                hs;
  } div_request_t;

  typedef struct {
    logic                over_speed;
    logic [SAMPLE_W-1:0] sample;
    logic [STEP_W-1:0]   step;
    logic                hs_en;
    logic [RATE_W-1:0]   rate;
  } div_setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  div_request_t request_q[$];
  div_setting_t setting_q[$];

  bit          stim_loaded = 1'b0;
  int unsigned sent_cnt = 0;
  int unsigned phase_len = 1;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned hold_at = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  i2c_clock_divider_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Three idling phases by requests sent: sender light / receiver heavy,
  // then the other way round, then no idling at all.
  assign tx_idle_pct = (sent_cnt < phase_len) ? 10 : (sent_cnt < 2 * phase_len) ? 49 : 0;
  assign rx_idle_pct = (sent_cnt < phase_len) ? 49 : (sent_cnt < 2 * phase_len) ? 10 : 0;

  // Exhaustive divisor search: sample outer, step inner, keep the first pair
  // with the strictly smallest shortfall below the target.
  function automatic div_setting_t search_divisors(input div_request_t req);
    div_setting_t res;
    int unsigned  step_lim;
    int unsigned  half_clk;
    int unsigned  best_gap;
    int unsigned  best_s;
    int unsigned  best_t;
    int unsigned  r;
    int unsigned  rate;
    step_lim = req.hs ? HS_STEP_DIV_MAX : STEP_DIV_MAX;
    half_clk = req.clock >> 1;
    best_gap = req.clock;
    best_s   = SAMPLE_DIV_MAX;
    best_t   = step_lim;
    for (int unsigned s = 1; s <= SAMPLE_DIV_MAX; s++) begin
      for (int unsigned t = 1; t <= step_lim; t++) begin
        r = half_clk / (s * t);
        if (r <= req.target && (req.target - r) < best_gap) begin
          best_gap = req.target - r;
          best_s   = s;
          best_t   = t;
        end
      end
    end
    rate = half_clk / (best_s * best_t);
    res = '{over_speed: 1'b0, sample: '0, step: '0, hs_en: 1'b0, rate: '0};
    if (rate > req.target) begin
      res.over_speed = 1'b1;
    end else begin
      res.sample = SAMPLE_W'(best_s - 1);
      res.step   = STEP_W'(best_t - 1);
      res.hs_en  = req.hs;
      res.rate   = RATE_W'(rate);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Sender: present the head of the request queue, advance on acceptance,
  // and log the predicted setting at the same edge.
  always @(posedge clk) begin
    bit fire;
    fire = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        setting_q.push_back(search_divisors(request_q[0]));
        void'(request_q.pop_front());
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_tvalid || fire) begin
        if (stim_loaded && request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {request_q[0].target, request_q[0].clock};
          in_tuser  <= request_q[0].hs;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, in the no-idling phase: the block fills
  // its output register, finishes the next request and then stalls its input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && rst_n && stim_loaded && sent_cnt == hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: random back-pressure, and check every accepted result against
  // the oldest prediction, field by field.
  always @(posedge clk) begin
    div_setting_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
      if (out_tvalid && out_tready) begin
        if (setting_q.size() == 0) begin
          report_mismatch("result with no request waiting", out_tdata[31:0], 0);
        end else begin
          want = setting_q.pop_front();
          if (out_tuser !== want.over_speed)
            report_mismatch("status", out_tuser, want.over_speed);
          if (out_tdata[2:0] !== want.sample)
            report_mismatch("sample_field", out_tdata[2:0], want.sample);
          if (out_tdata[8:3] !== want.step)
            report_mismatch("step_field", out_tdata[8:3], want.step);
          if (out_tdata[9] !== want.hs_en)
            report_mismatch("high_speed_enable", out_tdata[9], want.hs_en);
          if (out_tdata[32:10] !== want.rate)
            report_mismatch("achieved_rate", out_tdata[32:10], want.rate);
          if (out_tdata[39:33] !== '0)
            report_mismatch("tdata padding", out_tdata[39:33], 0);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    div_request_t req;
    int unsigned  step_lim;
    int unsigned  half_clk;
    int unsigned  lo;
    int unsigned  hi;

    // Directed: zero clock, extremes of every field, over-speed in both
    // modes, exact hits, ties and targets above the half clock.
    request_q.push_back('{clock: 24'd0,        target: 16'd0,     hs: 1'b0});
    request_q.push_back('{clock: 24'd0,        target: 16'hffff,  hs: 1'b1});
    request_q.push_back('{clock: 24'd1,        target: 16'd0,     hs: 1'b0});
    request_q.push_back('{clock: 24'd2,        target: 16'd0,     hs: 1'b1});
    request_q.push_back('{clock: 24'd3,        target: 16'd1,     hs: 1'b0});
    request_q.push_back('{clock: 24'd4,        target: 16'hffff,  hs: 1'b1});
    request_q.push_back('{clock: 24'hffffff,   target: 16'hffff,  hs: 1'b0});
    request_q.push_back('{clock: 24'hffffff,   target: 16'hffff,  hs: 1'b1});
    request_q.push_back('{clock: 24'hffffff,   target: 16'd0,     hs: 1'b0});
    request_q.push_back('{clock: 24'hffffff,   target: 16'd1,     hs: 1'b1});
    request_q.push_back('{clock: 24'hffffff,   target: 16'd16382, hs: 1'b0});
    request_q.push_back('{clock: 24'd16777214, target: 16'd16383, hs: 1'b0});
    request_q.push_back('{clock: 24'd12000,    target: 16'd100,   hs: 1'b0});
    request_q.push_back('{clock: 24'd12000,    target: 16'd400,   hs: 1'b0});
    request_q.push_back('{clock: 24'd12000,    target: 16'd3400,  hs: 1'b1});
    request_q.push_back('{clock: 24'd12000,    target: 16'd6000,  hs: 1'b1});
    request_q.push_back('{clock: 24'd12000,    target: 16'd6001,  hs: 1'b0});
    request_q.push_back('{clock: 24'd1024,     target: 16'd1,     hs: 1'b0});

    // Random: mostly targets within reach of the divisors, the rest anything.
    // Lean on high-speed mode, whose search covers eight times fewer pairs.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      req.hs    = ($urandom_range(99) < 60);
      req.clock = ($urandom_range(3) == 0) ? CLOCK_W'($urandom_range(65535))
                                           : CLOCK_W'($urandom());
      if ($urandom_range(99) < 25) begin
        req.target = TARGET_W'($urandom());
      end else begin
        step_lim = req.hs ? HS_STEP_DIV_MAX : STEP_DIV_MAX;
        half_clk = req.clock >> 1;
        lo = half_clk / (SAMPLE_DIV_MAX * step_lim);
        hi = (half_clk < 65535) ? half_clk : 65535;
        req.target = TARGET_W'($urandom_range(hi, lo));
      end
      request_q.push_back(req);
    end

    phase_len = request_q.size() / 3;
    hold_at   = 2 * phase_len + 3;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    stim_loaded = 1'b1;

    // Drain: every request taken, every result back, then a quiet stretch.
    while (request_q.size() != 0 || setting_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
